// File: rtl/ilid_pkg.sv
// Shared types, codes and constants for the indexed list store.
`timescale 1ns / 1ps

package ilid_pkg;

    // Store geometry. Length and position fields are 7 bits wide.
    localparam int C_CAPACITY = 64;
    localparam int C_ADDR_W   = $clog2(C_CAPACITY);
    localparam int C_CNT_W    = 7;
    localparam int C_CMD_W    = 3;
    localparam int C_DATA_W   = 32;

    // Command codes carried in the request.
    localparam logic [C_CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [C_CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [C_CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [C_CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [C_CMD_W-1:0] CMD_DELETE   = 3'd4;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What work a request needs once it has been checked.
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_READ = 2'd1,
        K_INS  = 2'd2,
        K_DEL  = 2'd3
    } t_kind;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic ins_step;
        logic del_step;
        logic put_new;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        t_kind kind;
        logic  ins_end;
        logic  del_end;
        logic  out_free;
    } t_dp_stat;

endpackage

// File: rtl/ilid_req_if.sv
// Request channel interface of the indexed list store.
`timescale 1ns / 1ps

interface ilid_req_if;
    import ilid_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [C_CMD_W-1:0]         cmd;
    logic [C_CNT_W-1:0]         position;
    logic signed [C_DATA_W-1:0] value_in;

    modport source (output valid, cmd, position, value_in, input ready);
    modport sink   (input valid, cmd, position, value_in, output ready);
endinterface

// File: rtl/ilid_rsp_if.sv
// Result channel interface of the indexed list store.
`timescale 1ns / 1ps

interface ilid_rsp_if;
    import ilid_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [C_DATA_W-1:0] value_out;
    logic [1:0]                 status;
    logic [C_CNT_W-1:0]         length;

    modport source (output valid, value_out, status, length, input ready);
    modport sink   (input valid, value_out, status, length, output ready);
endinterface

// File: rtl/ilid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/ilid_ctrl.sv
// Sequencing state machine of the indexed list store.
`timescale 1ns / 1ps

module ilid_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ilid_pkg::t_dp_stat  i_stat,
    output ilid_pkg::t_ctrl_cmd o_cmd
);
    import ilid_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_INS  = 6'b000100,
        S_PUT  = 6'b001000,
        S_DEL  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_stat.kind)
                        K_READ:  n_state = S_RD;
                        K_INS:   n_state = S_INS;
                        K_DEL:   n_state = S_DEL;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_FIN;
            end
            S_INS: begin
                o_cmd.ins_step = 1'b1;
                if (i_stat.ins_end) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put_new = 1'b1;
                n_state       = S_FIN;
            end
            S_DEL: begin
                o_cmd.del_step = 1'b1;
                if (i_stat.del_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: rtl/ilid_dp.sv
// Datapath of the indexed list store: request checks, entry memory, shift walk, result register.
`timescale 1ns / 1ps

module ilid_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ilid_pkg::t_ctrl_cmd                  i_cmd,
    output ilid_pkg::t_dp_stat                   o_stat,
    input  logic [ilid_pkg::C_CMD_W-1:0]         i_req_cmd,
    input  logic [ilid_pkg::C_CNT_W-1:0]         i_req_position,
    input  logic signed [ilid_pkg::C_DATA_W-1:0] i_req_value_in,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [ilid_pkg::C_DATA_W-1:0] o_value_out,
    output logic [1:0]                           o_status,
    output logic [ilid_pkg::C_CNT_W-1:0]         o_length
);
    import ilid_pkg::*;

    // Request decode results.
    t_kind                d_kind;
    t_status              d_st;
    logic [C_DATA_W-1:0]  d_vout;
    logic [C_CNT_W-1:0]   d_epos;

    // Work registers.
    t_kind                r_kind;
    t_status              r_st;
    logic [C_DATA_W-1:0]  r_vout;
    logic [C_CNT_W-1:0]   r_pos;
    logic [C_DATA_W-1:0]  r_val;
    logic [C_CNT_W-1:0]   r_ptr;
    logic [C_CNT_W-1:0]   n_ptr;
    logic                 r_wv;
    logic                 n_wv;
    logic [C_CNT_W-1:0]   r_count;
    logic [C_CNT_W-1:0]   n_count;

    // Result register.
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [C_DATA_W-1:0]  r_out_value;
    t_status              r_out_status;
    logic [C_CNT_W-1:0]   r_out_length;

    // Memory port signals.
    logic                 ram_re;
    logic [C_ADDR_W-1:0]  ram_raddr;
    logic                 ram_we;
    logic [C_ADDR_W-1:0]  ram_waddr;
    logic [C_DATA_W-1:0]  ram_wdata;
    logic [C_DATA_W-1:0]  ram_rdata;

    logic                 ins_end;
    logic                 del_end;
    logic [C_CNT_W-1:0]   ptr_dec;
    logic [C_CNT_W-1:0]   ptr_dec2;
    logic [C_CNT_W-1:0]   ptr_inc;

    always_comb begin
        d_kind = K_NONE;
        d_st   = ST_RANGE;
        d_vout = '0;
        d_epos = i_req_position;
        case (i_req_cmd)
            CMD_READ: begin
                if (i_req_position < r_count) begin
                    d_kind = K_READ;
                    d_st   = ST_DONE;
                end else begin
                    d_vout = '1;
                end
            end
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                if (i_req_cmd == CMD_INS_HEAD) begin
                    d_epos = '0;
                end else if (i_req_cmd == CMD_INS_TAIL) begin
                    d_epos = r_count;
                end
                // The range check takes precedence over the full check.
                if (d_epos > r_count) begin
                    d_st = ST_RANGE;
                end else if (r_count >= C_CNT_W'(C_CAPACITY)) begin
                    d_st = ST_FULL;
                end else begin
                    d_kind = K_INS;
                    d_st   = ST_DONE;
                end
            end
            CMD_DELETE: begin
                if (i_req_position < r_count) begin
                    d_kind = K_DEL;
                    d_st   = ST_DONE;
                end
            end
            default: ;
        endcase
    end

    assign ins_end  = (r_ptr == r_pos);
    assign del_end  = (r_ptr == r_count);
    assign ptr_dec  = r_ptr - C_CNT_W'(1);
    assign ptr_dec2 = r_ptr - C_CNT_W'(2);
    assign ptr_inc  = r_ptr + C_CNT_W'(1);

    // Insert walks down from the tail: read one below the pointer while the
    // word read the cycle before lands one above it. Delete walks up, reading at the
    // pointer while the word read before that lands two below it.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_pos[C_ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_pos[C_ADDR_W-1:0];
        ram_wdata = r_val;
        if (i_cmd.rd_issue) begin
            ram_re = 1'b1;
        end
        if (i_cmd.ins_step) begin
            ram_re    = !ins_end;
            ram_raddr = ptr_dec[C_ADDR_W-1:0];
            ram_we    = r_wv;
            ram_waddr = ptr_inc[C_ADDR_W-1:0];
            ram_wdata = ram_rdata;
        end
        if (i_cmd.del_step) begin
            ram_re    = !del_end;
            ram_raddr = r_ptr[C_ADDR_W-1:0];
            ram_we    = r_wv;
            ram_waddr = ptr_dec2[C_ADDR_W-1:0];
            ram_wdata = ram_rdata;
        end
        if (i_cmd.put_new) begin
            ram_we = 1'b1;
        end
    end

    ilid_ram #(
        .WIDTH (C_DATA_W),
        .DEPTH (C_CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_ptr       = r_ptr;
        n_wv        = r_wv;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (i_cmd.accept) begin
            n_ptr = (d_kind == K_INS) ? r_count : (i_req_position + C_CNT_W'(1));
            n_wv  = 1'b0;
        end
        if (i_cmd.ins_step) begin
            n_wv = !ins_end;
            if (!ins_end) begin
                n_ptr = ptr_dec;
            end
        end
        if (i_cmd.del_step) begin
            n_wv = !del_end;
            if (!del_end) begin
                n_ptr = ptr_inc;
            end else begin
                n_count = r_count - C_CNT_W'(1);
            end
        end
        if (i_cmd.put_new) begin
            n_count = r_count + C_CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.accept) begin
            r_kind <= d_kind;
            r_st   <= d_st;
            r_vout <= d_vout;
            r_pos  <= d_epos;
            r_val  <= i_req_value_in;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= (r_kind == K_READ) ? ram_rdata : r_vout;
            r_out_status <= r_st;
            r_out_length <= r_count;
        end
    end

    assign o_stat.kind     = d_kind;
    assign o_stat.ins_end  = ins_end;
    assign o_stat.del_end  = del_end;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_status    = r_out_status;
    assign o_length    = r_out_length;
endmodule

// File: rtl/indexed_list_insert_delete.sv
// Top level of the indexed list store: controller and datapath joined to the two channels.
`timescale 1ns / 1ps
// Usage:
// The block keeps an ordered list of up to 64 signed 32-bit values. Each request on i_req
// carries a command (read, insert at head, insert at tail, insert before a position, delete
// at a position), a position and a value; each request yields exactly one result on o_rsp
// holding the value read, a status (done, out of range, full) and the list length after it.
// Both channels use valid/ready; a request or result moves when both are high.
// A request is checked on acceptance. A read then reads the entry and loads the result; an
// insert shifts the entries from the tail down to position p (head p=0, tail p=n, with n the
// length), writes the new value and loads the result; a delete shifts the entries above p
// down and loads the result; a refused or unknown command loads the result directly. The
// controller is back in idle once the result is loaded and only then takes the next request;
// worst case is an insert at the head of a 63-entry list. That comes from the entry memory,
// which has one read and one write port: the shift walks one entry per cycle.
// Synchronous active-low reset empties the list; memory contents are not cleared, since only
// positions below the length are ever read. A finished result sits in an output register;
// while the receiver stalls, the block still takes and works on the next request, and waits
// only when that request's result is ready and the output register is still full.
module indexed_list_insert_delete (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilid_req_if.sink   i_req,
    ilid_rsp_if.source o_rsp
);
    import ilid_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    // The controller only sequences; every register that holds list state lives in the
    // datapath, and the two talk through one command and one status struct.
    ilid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_stat  (dp_stat),
        .o_cmd   (ctrl_cmd)
    );

    // The datapath checks each request against the current length when it is
    // accepted, so the controller learns at once whether any memory work is needed.
    ilid_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_stat         (dp_stat),
        .i_req_cmd      (i_req.cmd),
        .i_req_position (i_req.position),
        .i_req_value_in (i_req.value_in),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_value_out    (o_rsp.value_out),
        .o_status       (o_rsp.status),
        .o_length       (o_rsp.length)
    );
endmodule
